/* design/erm_pkg.sv */
`default_nettype none

package erm_pkg;

   // cordic datapath width: q2.30 vectors plus guard bits
   localparam int CW = 34;
   // fraction bits of the internal products
   localparam int QFRAC = 30;

   typedef logic signed [CW-1:0] cval_type;

   typedef struct packed {
      cval_type c;
      cval_type s;
   } sincos_type;

   // round(K * 2^30), the cordic limit gain
   localparam cval_type CORDIC_GAIN = 34'sd652032874;

   // atan(2^-i) as a 32-bit binary angle
   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // q30 product, rounded half up
   function automatic cval_type mulq(input cval_type a, input cval_type b);
      logic signed [2*CW-1:0] p;
      p = (2*CW)'(a) * (2*CW)'(b) + ((2*CW)'(1) <<< (QFRAC - 1));
      return cval_type'(p >>> QFRAC);
   endfunction

endpackage

`default_nettype wire

/* design/euler_rotation_matrix.sv */
`default_nettype none

// channel  dir  handshake            payload
// req      in   req_tvalid/tready    angle_x, angle_y, angle_z
// rsp      out  rsp_tvalid/tready    m00 m01 m02 m10 m11 m12 m20 m21 m22
//
// the pipeline has one start stage and one stage per cordic step in each of
// the three angle lanes, then two multiplier stages and the output register.
// a new transfer is taken every cycle unless the output is stalled.
// reset clears only the valid bits. a stalled output holds the whole
// pipeline, so req_tready follows rsp_tready while a result is waiting.

module euler_rotation_matrix #(
   parameter int ANGLE_BITS      = 16,
   parameter int ENTRY_FRAC_BITS = 14,
   parameter int CORDIC_STEPS    = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // angle_x, angle_y, angle_z, zero pad
   input  wire logic [((3*ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero pad
   output logic [((9*(ENTRY_FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata
);
   import erm_pkg::*;

   localparam int OB    = ENTRY_FRAC_BITS + 2;
   localparam int LAT   = CORDIC_STEPS + 4;
   localparam int RSP_W = ((9*OB+7)/8)*8;

   logic            en;
   logic [LAT-1:0]  vld_ff, vld_in;
   sincos_type      sc_x, sc_y, sc_z;
   logic [9*OB-1:0] entries;

   // the pipeline moves unless a finished result is held
   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];

   // valid bits follow the data stages
   assign vld_in = {vld_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   erm_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_x (
      .clock (clock),
      .en    (en),
      .angle (req_tdata[0*ANGLE_BITS +: ANGLE_BITS]),
      .sc    (sc_x)
   );

   erm_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_y (
      .clock (clock),
      .en    (en),
      .angle (req_tdata[1*ANGLE_BITS +: ANGLE_BITS]),
      .sc    (sc_y)
   );

   erm_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_z (
      .clock (clock),
      .en    (en),
      .angle (req_tdata[2*ANGLE_BITS +: ANGLE_BITS]),
      .sc    (sc_z)
   );

   erm_merge #(.ENTRY_FRAC_BITS(ENTRY_FRAC_BITS)) u_merge (
      .clock   (clock),
      .en      (en),
      .sc_x    (sc_x),
      .sc_y    (sc_y),
      .sc_z    (sc_z),
      .entries (entries)
   );

   assign rsp_tdata = RSP_W'(entries);

endmodule

`default_nettype wire

/* design/erm_cordic_lane.sv */
`default_nettype none

module erm_cordic_lane #(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [ANGLE_BITS-1:0] angle,
   output erm_pkg::sincos_type        sc
);
   import erm_pkg::*;

   localparam int S = CORDIC_STEPS;

   cval_type   x_ff [0:S];
   cval_type   y_ff [0:S];
   cval_type   z_ff [0:S];
   logic [1:0] q_ff [0:S];
   logic [31:0] wide;

   // widen the angle to a 32-bit binary angle
   assign wide = 32'(angle) << (32 - ANGLE_BITS);

   // first stage: quadrant split and cordic start vector
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= CORDIC_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= cval_type'({4'b0000, wide[29:0]});
         q_ff[0] <= wide[31:30];
      end
   end

   // one micro-rotation per stage
   for (genvar k = 0; k < S; k++) begin : g_step
      cval_type x_in, y_in, z_in, dx, dy, at;
      assign dx = y_ff[k] >>> k;
      assign dy = x_ff[k] >>> k;
      assign at = cval_type'({2'b00, ATAN_TABLE[k]});
      always_comb begin
         if (!z_ff[k][CW-1]) begin
            x_in = x_ff[k] - dx;
            y_in = y_ff[k] + dy;
            z_in = z_ff[k] - at;
         end else begin
            x_in = x_ff[k] + dx;
            y_in = y_ff[k] - dy;
            z_in = z_ff[k] + at;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k+1] <= x_in;
            y_ff[k+1] <= y_in;
            z_ff[k+1] <= z_in;
            q_ff[k+1] <= q_ff[k];
         end
      end
   end

   // quadrant fold by exact swaps and negations
   always_comb begin
      case (q_ff[S])
         2'd0: begin
            sc.c = x_ff[S];
            sc.s = y_ff[S];
         end
         2'd1: begin
            sc.c = -y_ff[S];
            sc.s = x_ff[S];
         end
         2'd2: begin
            sc.c = -x_ff[S];
            sc.s = -y_ff[S];
         end
         default: begin
            sc.c = y_ff[S];
            sc.s = -x_ff[S];
         end
      endcase
   end

endmodule

`default_nettype wire

/* design/erm_merge.sv */
`default_nettype none

module erm_merge #(
   parameter int ENTRY_FRAC_BITS = 14
) (
   input  wire logic                             clock,
   input  wire logic                             en,
   input  wire erm_pkg::sincos_type              sc_x,
   input  wire erm_pkg::sincos_type              sc_y,
   input  wire erm_pkg::sincos_type              sc_z,
   output logic [9*(ENTRY_FRAC_BITS+2)-1:0]      entries
);
   import erm_pkg::*;

   localparam int OB = ENTRY_FRAC_BITS + 2;
   localparam int SH = QFRAC - ENTRY_FRAC_BITS;
   localparam int VW = CW + 1;
   localparam int RW = CW + 2;
   localparam logic signed [RW-1:0] HALF2 = RW'(1) <<< SH;
   localparam logic signed [RW-1:0] LIM   = RW'(1) <<< ENTRY_FRAC_BITS;

   // round half up, then clamp to plus or minus one
   function automatic logic [OB-1:0] to_entry(input logic signed [VW-1:0] v);
      logic signed [RW-1:0] r;
      r = (RW'(v) <<< 1) + HALF2;
      r = r >>> (SH + 1);
      if (r > LIM)
         r = LIM;
      if (r < -LIM)
         r = -LIM;
      return r[OB-1:0];
   endfunction

   cval_type cycz_ff, cysz_ff, sxsy_ff, cxsy_ff, cxsz_ff, cxcz_ff;
   cval_type sxcy_ff, sxsz_ff, sxcz_ff, cxcy_ff, sy_ff, cz_ff, sz_ff;
   cval_type p00_ff, p01_ff, p02_ff, p10_ff, p10b_ff, p11_ff, p11b_ff;
   cval_type p12_ff, p20_ff, p20b_ff, p21_ff, p21b_ff, p22_ff;
   logic [9*OB-1:0] entries_ff, entries_in;

   // pair products
   always_ff @(posedge clock) begin
      if (en) begin
         cycz_ff <= mulq(sc_y.c, sc_z.c);
         cysz_ff <= mulq(sc_y.c, sc_z.s);
         sxsy_ff <= mulq(sc_x.s, sc_y.s);
         cxsy_ff <= mulq(sc_x.c, sc_y.s);
         cxsz_ff <= mulq(sc_x.c, sc_z.s);
         cxcz_ff <= mulq(sc_x.c, sc_z.c);
         sxcy_ff <= mulq(sc_x.s, sc_y.c);
         sxsz_ff <= mulq(sc_x.s, sc_z.s);
         sxcz_ff <= mulq(sc_x.s, sc_z.c);
         cxcy_ff <= mulq(sc_x.c, sc_y.c);
         sy_ff   <= sc_y.s;
         cz_ff   <= sc_z.c;
         sz_ff   <= sc_z.s;
      end
   end

   // triple products, pair terms carried along
   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff  <= cycz_ff;
         p01_ff  <= cysz_ff;
         p02_ff  <= sy_ff;
         p10_ff  <= mulq(sxsy_ff, cz_ff);
         p10b_ff <= cxsz_ff;
         p11_ff  <= cxcz_ff;
         p11b_ff <= mulq(sxsy_ff, sz_ff);
         p12_ff  <= sxcy_ff;
         p20_ff  <= sxsz_ff;
         p20b_ff <= mulq(cxsy_ff, cz_ff);
         p21_ff  <= mulq(cxsy_ff, sz_ff);
         p21b_ff <= sxcz_ff;
         p22_ff  <= cxcy_ff;
      end
   end

   // sums, rounding and saturation
   always_comb begin
      entries_in[0*OB +: OB] = to_entry(VW'(p00_ff));
      entries_in[1*OB +: OB] = to_entry(-VW'(p01_ff));
      entries_in[2*OB +: OB] = to_entry(VW'(p02_ff));
      entries_in[3*OB +: OB] = to_entry(VW'(p10_ff) + VW'(p10b_ff));
      entries_in[4*OB +: OB] = to_entry(VW'(p11_ff) - VW'(p11b_ff));
      entries_in[5*OB +: OB] = to_entry(-VW'(p12_ff));
      entries_in[6*OB +: OB] = to_entry(VW'(p20_ff) - VW'(p20b_ff));
      entries_in[7*OB +: OB] = to_entry(VW'(p21_ff) + VW'(p21b_ff));
      entries_in[8*OB +: OB] = to_entry(VW'(p22_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         entries_ff <= entries_in;
      end
   end

   assign entries = entries_ff;

endmodule

`default_nettype wire

/* design/erm_checker.sv */
`default_nettype none

module erm_checker #(
   parameter int ENTRY_FRAC_BITS = 14
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [((9*(ENTRY_FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata
);
   localparam int OB = ENTRY_FRAC_BITS + 2;
   localparam logic signed [OB-1:0] LIM = OB'(1) <<< ENTRY_FRAC_BITS;

   logic signed [OB-1:0] m00, m22;

   assign m00 = rsp_tdata[0*OB +: OB];
   assign m22 = rsp_tdata[8*OB +: OB];

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // input side only stalls while a result waits
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready out of step with output stall");

   // a held result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // diagonal corners stay within plus or minus one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> m00 <= LIM && m00 >= -LIM && m22 <= LIM && m22 >= -LIM)
      else $error("entry outside saturation range");

endmodule

bind euler_rotation_matrix erm_checker #(.ENTRY_FRAC_BITS(ENTRY_FRAC_BITS)) u_erm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* verif/tb_euler_rotation_matrix.sv */
`timescale 1ns / 1ps

module tb_euler_rotation_matrix;
   import erm_pkg::*;

   localparam int ANGLE_BITS      = 16;
   localparam int ENTRY_FRAC_BITS = 14;
   localparam int CORDIC_STEPS    = 16;
   localparam int OUT_BITS        = ENTRY_FRAC_BITS + 2;
   localparam int REQ_W           = ((3*ANGLE_BITS+7)/8)*8;
   localparam int RSP_W           = ((9*OUT_BITS+7)/8)*8;
   localparam int N_RANDOM        = 1900;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = CORDIC_STEPS + 20;

   typedef logic signed [63:0] wide_type;
   typedef logic [OUT_BITS-1:0] entry_type;
   typedef entry_type [8:0] matrix_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;

   int mismatches = 0;
   int idle_cycles = 0;
   bit input_done = 0;

   euler_rotation_matrix #(
      .ANGLE_BITS(ANGLE_BITS),
      .ENTRY_FRAC_BITS(ENTRY_FRAC_BITS),
      .CORDIC_STEPS(CORDIC_STEPS)
   ) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // clock
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   // arithmetic shift right on 64 bits
   function automatic wide_type sar(input wide_type v, input int s);
      return v >>> s;
   endfunction

   function automatic wide_type qmul(input wide_type a, input wide_type b);
      return sar(a * b + (64'sd1 <<< 29), 30);
   endfunction

   // fixed-length cordic with quadrant folding
   function automatic void angle_sincos(input logic [ANGLE_BITS-1:0] ang,
                                        output wide_type c, output wide_type s);
      logic [31:0] a;
      logic [1:0] quad;
      wide_type x, y, z, nx;
      a = 32'(ang) << (32 - ANGLE_BITS);
      quad = a[31:30];
      z = wide_type'(a[29:0]);
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
         if (z >= 0) begin
            nx = x - sar(y, i);
            y = y + sar(x, i);
            z = z - wide_type'(ATAN_TABLE[i]);
         end else begin
            nx = x + sar(y, i);
            y = y - sar(x, i);
            z = z + wide_type'(ATAN_TABLE[i]);
         end
         x = nx;
      end
      case (quad)
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   // round to entry precision and clamp to +-1.0
   function automatic entry_type to_entry(input wide_type v);
      int sh = 30 - ENTRY_FRAC_BITS;
      wide_type lim = 64'sd1 <<< ENTRY_FRAC_BITS;
      if (sh > 0) v = sar(v + (64'sd1 <<< (sh - 1)), sh);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return entry_type'(v);
   endfunction

   function automatic void rotation_matrix(input logic [ANGLE_BITS-1:0] ax, ay, az,
                                           output matrix_type m);
      wide_type cx, sx, cy, sy, cz, sz, sxsy, cxsy;
      angle_sincos(ax, cx, sx);
      angle_sincos(ay, cy, sy);
      angle_sincos(az, cz, sz);
      sxsy = qmul(sx, sy);
      cxsy = qmul(cx, sy);
      m[0] = to_entry(qmul(cy, cz));
      m[1] = to_entry(-qmul(cy, sz));
      m[2] = to_entry(sy);
      m[3] = to_entry(qmul(sxsy, cz) + qmul(cx, sz));
      m[4] = to_entry(qmul(cx, cz) - qmul(sxsy, sz));
      m[5] = to_entry(-qmul(sx, cy));
      m[6] = to_entry(qmul(sx, sz) - qmul(cxsy, cz));
      m[7] = to_entry(qmul(cxsy, sz) + qmul(sx, cz));
      m[8] = to_entry(qmul(cx, cy));
   endfunction

   // matrices still owed by the block, oldest first
   class matrix_scoreboard;
      matrix_type pending[$];

      function void note_angles(input logic [REQ_W-1:0] d);
         matrix_type m;
         rotation_matrix(d[0 +: ANGLE_BITS], d[ANGLE_BITS +: ANGLE_BITS],
                         d[2*ANGLE_BITS +: ANGLE_BITS], m);
         pending.push_back(m);
      endfunction

      task check_matrix(input logic [RSP_W-1:0] d);
         matrix_type m;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected matrix %h", d));
            return;
         end
         m = pending.pop_front();
         for (int k = 0; k < 9; k++)
            if (d[k*OUT_BITS +: OUT_BITS] !== m[k])
               report_mismatch($sformatf("m%0d%0d got %h want %h", k / 3, k % 3,
                                         d[k*OUT_BITS +: OUT_BITS], m[k]));
         if ((d >> (9*OUT_BITS)) !== '0)
            report_mismatch("nonzero pad in rsp_tdata");
      endtask
   endclass

   matrix_scoreboard sb = new();

   // monitor both channels on each rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_angles(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_matrix(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side stalls at random, with recurring stretches of no stalling
   initial begin : rsp_side
      int gap;
      int count;
      count = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = (input_done || (count % 400 < 50)) ? 0 : $urandom_range(0, 15);
         if ($urandom_range(0, 3) == 0) gap = 0;
         count++;
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_angles(input logic [15:0] ax, ay, az, input int gap);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= REQ_W'({az, ay, ax});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_matrices();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0 && idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
   endtask

   logic [15:0] corner[] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                             16'h3FFF, 16'h2000, 16'h0001};

   // stimulus
   initial begin : req_side
      int gap;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // quadrant boundaries, extremes and near-singular angles
      for (int i = 0; i < corner.size(); i++)
         send_angles(corner[i], corner[(i + 3) % corner.size()],
                     corner[(i + 5) % corner.size()], 0);
      send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
      send_angles(16'h0000, 16'h4000, 16'h0000, 1);
      send_angles(16'h0000, 16'hC000, 16'h1234, 2);
      send_angles(16'h5555, 16'hAAAA, 16'h5555, 0);
      send_angles(16'hAAAA, 16'h5555, 16'hAAAA, 0);
      // hold off until every matrix is back
      drain_matrices();
      for (int n = 0; n < N_RANDOM; n++) begin
         gap = (n / 200) % 3 == 1 ? 0 : $urandom_range(0, 15);
         if (n == N_RANDOM / 2) drain_matrices();
         send_angles(16'($urandom), 16'($urandom), 16'($urandom), gap);
      end
      req_tvalid <= 0;
      input_done = 1;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* files.f */
design/erm_pkg.sv
design/erm_cordic_lane.sv
design/erm_merge.sv
design/euler_rotation_matrix.sv
design/erm_checker.sv
verif/tb_euler_rotation_matrix.sv
